FILE: src/aes128_pkg.sv
// Package for the AES-128 key expansion block.
// Holds widths, the S-box, round constants, controller state type and command struct. No dependencies.
package aes128_pkg;

  localparam int unsigned KeyHalfW  = 64;
  localparam int unsigned WordW     = 32;
  localparam int unsigned RoundW    = 4;
  localparam int unsigned NumRounds = 10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } ctrl_state_e;

  // controller -> datapath commands
  typedef struct packed {
    logic load;   // take the key from the input beat
    logic step;   // advance to the next round key
  } dp_cmd_t;

  function automatic logic [7:0] sbox(input logic [7:0] b);
    logic [7:0] r;
    unique case (b)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r=8'h00;
    endcase
    return r;
  endfunction

  // round constant for the round being produced (1..10)
  function automatic logic [7:0] rcon(input logic [RoundW-1:0] rnd);
    logic [7:0] r;
    unique case (rnd)
      4'd1: r = 8'h01;  4'd2: r = 8'h02;  4'd3: r = 8'h04;  4'd4: r = 8'h08;
      4'd5: r = 8'h10;  4'd6: r = 8'h20;  4'd7: r = 8'h40;  4'd8: r = 8'h80;
      4'd9: r = 8'h1b;  4'd10: r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

FILE: src/aes128_if.sv
// Valid/ready channel interfaces for the key expansion block.
// Depends on aes128_pkg for field widths.
interface aes128_key_if import aes128_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KeyHalfW-1:0] cipher_key_high;
  logic [KeyHalfW-1:0] cipher_key_low;
  modport source (output valid, cipher_key_high, cipher_key_low, input ready);
  modport sink   (input valid, cipher_key_high, cipher_key_low, output ready);
endinterface

interface aes128_rkey_if import aes128_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RoundW-1:0]   round_number;
  logic [KeyHalfW-1:0] round_key_high;
  logic [KeyHalfW-1:0] round_key_low;
  logic                last_round;
  modport source (output valid, round_number, round_key_high, round_key_low, last_round,
                  input ready);
  modport sink   (input valid, round_number, round_key_high, round_key_low, last_round,
                  output ready);
endinterface

FILE: src/aes128_datapath.sv
// Round key register and one-round expansion logic.
// Depends on aes128_pkg (S-box, round constants, command struct).
module aes128_datapath import aes128_pkg::*; (
  input  logic                clk_i,
  input  dp_cmd_t             cmd_i,
  input  logic [KeyHalfW-1:0] key_high_i,
  input  logic [KeyHalfW-1:0] key_low_i,
  output logic [RoundW-1:0]   round_o,
  output logic [KeyHalfW-1:0] rkey_high_o,
  output logic [KeyHalfW-1:0] rkey_low_o
);

  logic [WordW-1:0]  w_q [4];
  logic [WordW-1:0]  w_d [4];
  logic [RoundW-1:0] round_q, round_d;
  logic [RoundW-1:0] round_nxt;
  logic [WordW-1:0]  rot, temp;

  assign round_nxt = round_q + RoundW'(1);
  assign rot       = {w_q[3][23:0], w_q[3][31:24]};
  assign temp      = {sbox(rot[31:24]) ^ rcon(round_nxt), sbox(rot[23:16]),
                      sbox(rot[15:8]), sbox(rot[7:0])};

  always_comb begin
    w_d     = w_q;
    round_d = round_q;
    if (cmd_i.load) begin
      w_d[0]  = key_high_i[63:32];
      w_d[1]  = key_high_i[31:0];
      w_d[2]  = key_low_i[63:32];
      w_d[3]  = key_low_i[31:0];
      round_d = '0;
    end else if (cmd_i.step) begin
      w_d[0]  = w_q[0] ^ temp;
      w_d[1]  = w_q[1] ^ w_q[0] ^ temp;
      w_d[2]  = w_q[2] ^ w_q[1] ^ w_q[0] ^ temp;
      w_d[3]  = w_q[3] ^ w_q[2] ^ w_q[1] ^ w_q[0] ^ temp;
      round_d = round_nxt;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q     <= w_d;
    round_q <= round_d;
  end

  assign round_o     = round_q;
  assign rkey_high_o = {w_q[0], w_q[1]};
  assign rkey_low_o  = {w_q[2], w_q[3]};

endmodule

FILE: src/aes128_ctrl.sv
// Controller: accepts a key beat, then sequences eleven round-key beats.
// Depends on aes128_pkg (state enum, command struct).
module aes128_ctrl import aes128_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  logic [RoundW-1:0] round_i,
  output logic              last_o,
  output dp_cmd_t           cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign last_o = (round_i == RoundW'(NumRounds));

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (last_o) begin
            // final beat taken: next key may load in the same edge
            in_ready_o = 1'b1;
            if (in_valid_i) begin
              cmd_o.load = 1'b1;
            end else begin
              state_d = ST_IDLE;
            end
          end else begin
            cmd_o.step = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: src/aes128_key_expansion.sv
// AES-128 key expansion top level.
// A key beat in on key_in (cipher_key_high carries key bytes 0..7, byte 0 on
// top; cipher_key_low bytes 8..15) yields eleven beats on rkey_out: round
// keys 0..10 in order, each tagged with round_number, and last_round set on
// round 10.
// Round 0 is offered in the cycle after the key beat is taken; each further
// round follows in the cycle after the previous beat is taken. The single
// round unit computes one round key per cycle from the one before it while
// rkey_out is not stalled. The next key beat is taken on the same edge as
// the round 10 beat.
// A stall on rkey_out holds the current round key and round number; key_in
// stays not ready until all eleven beats of the key have gone.
// Reset (rst_ni low, asynchronous) returns the controller to idle; any run in
// progress is dropped. Datapath registers are not reset.
module aes128_key_expansion import aes128_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  aes128_key_if.sink     key_in,
  aes128_rkey_if.source  rkey_out
);

  dp_cmd_t           cmd;
  logic [RoundW-1:0] round;

  aes128_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (key_in.valid),
    .in_ready_o  (key_in.ready),
    .out_valid_o (rkey_out.valid),
    .out_ready_i (rkey_out.ready),
    .round_i     (round),
    .last_o      (rkey_out.last_round),
    .cmd_o       (cmd)
  );

  aes128_datapath u_dp (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .key_high_i  (key_in.cipher_key_high),
    .key_low_i   (key_in.cipher_key_low),
    .round_o     (round),
    .rkey_high_o (rkey_out.round_key_high),
    .rkey_low_o  (rkey_out.round_key_low)
  );

  assign rkey_out.round_number = round;

endmodule
